@@ hw/rtl/nbw_pkg.sv @@
// shared types and constants of the nal bitstream writer
package nbw_pkg;

    // item kinds
    localparam logic [1:0] KIND_CODE   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [5:0] CODE_MAX_LEN = 6'd32;
    localparam logic [7:0] EP_BYTE      = 8'h03;

    localparam int ZERO_RUN_LIMIT_DEF = 2;
    localparam int ZR_W               = 2;
    localparam int JOBQ_ADDR_W_DEF    = 1;
    localparam int OUTQ_ADDR_W_DEF    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] code_value;
        logic [5:0]  code_length;
        logic [7:0]  header_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // up to four bytes, left-aligned, sent first byte first
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        header;
        logic        last;
    } job_t;

endpackage

@@ hw/rtl/nal_bitstream_writer_top.sv @@
// top level of the nal bitstream writer
//
// items enter through a queue-like port: item carries kind, code_value,
// code_length and header_byte; a transaction takes place when push is high
// and full is low. results leave through a queue-like port: result holds
// out_byte and last for the oldest waiting byte while empty is low, and a
// transaction takes place when pop is high and empty is low.
// the front end packs code bits into whole bytes combinationally and hands
// jobs of up to four bytes to a two-entry job queue; the back end sends one
// byte per cycle while the result queue has room into a four-entry result
// queue, inserting the escape byte where a payload byte of at most 0x03 would
// follow a zero run of the limit. an item's first result byte passes the job
// queue, the back end's job register and the result queue to the result port
// and can then be popped; the back end's byte rate sets the sustained rate,
// and an item that completes n bytes (plus any escape bytes) needs that many
// sends, up to four for a full 32-bit code; items with no byte send no job.
// when the receiver stalls the result queue fills, the back end waits and
// full rises once the job queue is taken up; nothing is lost.
// reset clears packing state, zero run, both queues and the unit state.
module nal_bitstream_writer_top
    import nbw_pkg::*;
#(
    parameter int ZERO_RUN_LIMIT = ZERO_RUN_LIMIT_DEF,
    parameter int JOBQ_ADDR_W    = JOBQ_ADDR_W_DEF,
    parameter int OUTQ_ADDR_W    = OUTQ_ADDR_W_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    push,
    output logic    full,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    job_t    front_job;
    logic    front_job_valid;
    logic    accept;
    logic    jq_full;
    logic    jq_empty;
    logic    jq_take;
    job_t    jq_head;
    result_t back_res;
    logic    back_res_valid;
    logic    oq_full;

    // an item is only taken while the job queue has room
    assign full   = jq_full;
    assign accept = push && !jq_full;

    nbw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .accept    (accept),
        .job       (front_job),
        .job_valid (front_job_valid)
    );

    // decouples classification from byte sending
    nbw_fifo #(
        .WIDTH  ($bits(job_t)),
        .ADDR_W (JOBQ_ADDR_W)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && front_job_valid),
        .wr_data (front_job),
        .full    (jq_full),
        .rd_en   (jq_take),
        .rd_data (jq_head),
        .empty   (jq_empty)
    );

    nbw_back #(
        .ZERO_RUN_LIMIT (ZERO_RUN_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (jq_head),
        .job_avail (!jq_empty),
        .job_take  (jq_take),
        .res       (back_res),
        .res_valid (back_res_valid),
        .res_full  (oq_full)
    );

    // result queue towards the receiver
    nbw_fifo #(
        .WIDTH  ($bits(result_t)),
        .ADDR_W (OUTQ_ADDR_W)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_res_valid),
        .wr_data (back_res),
        .full    (oq_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

@@ hw/rtl/nbw_fifo.sv @@
// small register queue with registered occupancy
module nbw_fifo
    import nbw_pkg::*;
#(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic [ADDR_W:0]   count_reg;
    logic [ADDR_W:0]   count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == (ADDR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/nbw_front.sv @@
// front end: classifies items and packs code bits into whole bytes
module nbw_front
    import nbw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  accept,
    output job_t  job,
    output logic  job_valid
);

    logic [6:0]  pending_bits_reg;
    logic [6:0]  pending_bits_next;
    logic [2:0]  pending_count_reg;
    logic [2:0]  pending_count_next;
    logic        payload_started_reg;
    logic        payload_started_next;

    logic [5:0]  len_c;
    logic [32:0] mask33;
    logic [31:0] code_bits;
    logic [38:0] joined;
    logic [38:0] shifted;
    logic [5:0]  total;
    logic [2:0]  rem;
    logic [2:0]  nbytes;
    logic [31:0] aligned;
    logic [7:0]  pend_mask;
    logic [7:0]  stop_src;
    logic [7:0]  end_byte;

    // bit packing datapath
    always_comb
    begin
        len_c     = (item.code_length > CODE_MAX_LEN) ? CODE_MAX_LEN : item.code_length;
        mask33    = (33'd1 << len_c) - 33'd1;
        code_bits = {16'b0, item.code_value} & mask33[31:0];
        joined    = ({32'b0, pending_bits_reg} << len_c) | {7'b0, code_bits};
        total     = {3'b0, pending_count_reg} + len_c;
        rem       = total[2:0];
        nbytes    = total[5:3];
        shifted   = joined >> rem;
        aligned   = shifted[31:0] << {3'd4 - nbytes, 3'b000};
        pend_mask = (8'd1 << rem) - 8'd1;
        stop_src  = {pending_bits_reg, 1'b1};
        end_byte  = stop_src << (3'd7 - pending_count_reg);
    end

    // classification and next state
    always_comb
    begin
        job                  = '0;
        job_valid            = 1'b0;
        pending_bits_next    = pending_bits_reg;
        pending_count_next   = pending_count_reg;
        payload_started_next = payload_started_reg;
        case (item.kind)
            KIND_CODE:
            begin
                if (len_c != '0)
                begin
                    payload_started_next = 1'b1;
                    pending_bits_next    = joined[6:0] & pend_mask[6:0];
                    pending_count_next   = rem;
                    job.word             = aligned;
                    job.cnt              = nbytes;
                    job_valid            = (nbytes != '0);
                end
            end
            KIND_HEADER:
            begin
                job.word   = {item.header_byte, 24'b0};
                job.cnt    = 3'd1;
                job.header = 1'b1;
                job_valid  = !payload_started_reg;
            end
            KIND_END:
            begin
                job.word             = {end_byte, 24'b0};
                job.cnt              = 3'd1;
                job.last             = 1'b1;
                job_valid            = 1'b1;
                pending_bits_next    = '0;
                pending_count_next   = '0;
                payload_started_next = 1'b0;
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bits_reg    <= '0;
            pending_count_reg   <= '0;
            payload_started_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_bits_reg    <= pending_bits_next;
            pending_count_reg   <= pending_count_next;
            payload_started_reg <= payload_started_next;
        end
    end

endmodule

@@ hw/rtl/nbw_back.sv @@
// back end: sends job bytes one per cycle while the result queue has room, with emulation prevention
module nbw_back
    import nbw_pkg::*;
#(
    parameter int ZERO_RUN_LIMIT = ZERO_RUN_LIMIT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    job,
    input  logic    job_avail,
    output logic    job_take,
    output result_t res,
    output logic    res_valid,
    input  logic    res_full
);

    localparam logic [ZR_W-1:0] LIMIT = ZR_W'(ZERO_RUN_LIMIT);

    logic            cur_valid_reg;
    logic            cur_valid_next;
    job_t            cur_reg;
    job_t            cur_next;
    logic [ZR_W-1:0] zero_run_reg;
    logic [ZR_W-1:0] zero_run_next;
    logic [7:0]      cur_byte;
    logic            escape;
    logic            finish;

    assign cur_byte = cur_reg.word[31:24];
    assign escape   = !cur_reg.header && (zero_run_reg >= LIMIT) && (cur_byte[7:2] == '0);
    assign finish   = cur_valid_reg && !res_full && !escape && (cur_reg.cnt == 3'd1);
    assign job_take = job_avail && (!cur_valid_reg || finish);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        zero_run_next  = zero_run_reg;
        res            = '0;
        res_valid      = 1'b0;
        if (cur_valid_reg && !res_full)
        begin
            res_valid = 1'b1;
            if (escape)
            begin
                res.out_byte  = EP_BYTE;
                zero_run_next = '0;
            end
            else
            begin
                res.out_byte  = cur_byte;
                res.last      = cur_reg.last && (cur_reg.cnt == 3'd1);
                cur_next.word = {cur_reg.word[23:0], 8'b0};
                cur_next.cnt  = cur_reg.cnt - 3'd1;
                if (!cur_reg.header)
                begin
                    if (cur_byte != '0)
                    begin
                        zero_run_next = '0;
                    end
                    else if (zero_run_reg < LIMIT)
                    begin
                        zero_run_next = zero_run_reg + 1'b1;
                    end
                end
                // end of unit starts the next one clean
                if (res.last)
                begin
                    zero_run_next = '0;
                end
                if (cur_reg.cnt == 3'd1)
                begin
                    cur_valid_next = 1'b0;
                end
            end
        end
        if (job_take)
        begin
            cur_valid_next = 1'b1;
            cur_next       = job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            zero_run_reg  <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            zero_run_reg  <= zero_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

`ifndef NO_ASSERTIONS
    a_zero_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        zero_run_reg <= LIMIT)
        else $error("zero run beyond limit");

    a_last_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> (zero_run_reg == '0))
        else $error("zero run kept across unit end");

    a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.cnt != '0))
        else $error("active job with no bytes");

    a_escape_after_zeros: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && escape) |-> (zero_run_reg >= LIMIT))
        else $error("escape without zero run");
`endif

endmodule
